[rtl/core/gcdg_pkg.sv]
// Shared constants, types and helper functions for the gray central-difference gradient block.
// No dependencies; every other file in rtl/core imports this package.

package gcdg_pkg;

	// Frame limits
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	// Fixed field widths
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	// Derived widths
	localparam int LB_DEPTH = 2 * MAX_WIDTH;
	localparam int ADDR_W   = $clog2(LB_DEPTH);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int EW       = $clog2(MAX_WIDTH + 2);

	// Register defaults, saturated to the frame limits
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	// Q16 luma weights for 0.30, 0.59 and 0.11; they sum to 65536
	localparam int WT_W       = 16;
	localparam int PROD_W     = PIX_W + WT_W;
	localparam int GRAY_SHIFT = 16;
	localparam logic [WT_W-1:0] WT_RED   = 16'd19661;
	localparam logic [WT_W-1:0] WT_GREEN = 16'd38666;
	localparam logic [WT_W-1:0] WT_BLUE  = 16'd7209;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [EW-1:0]     wid_t;
	typedef logic [PROD_W-1:0] prod_t;

	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_FLUSH = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Line buffer access for one cycle: two reads and one write
	typedef struct packed {
		logic  rd_en;
		addr_t rd_a_addr;
		addr_t rd_b_addr;
		logic  wr_en;
		addr_t wr_addr;
		pix_t  wr_data;
	} lb_req_t;

	// Saturate a size register to 1..lim; zero acts as one
	function automatic int clamp_dim(logic [CFG_W-1:0] v, int lim);
		int d;
		d = int'(v);
		if (d < 1)
			return 1;
		if (d > lim)
			return lim;
		return d;
	endfunction

	// |a-b| >> 1, equal to |(a-b)/2| with truncation toward zero
	function automatic pix_t half_abs(pix_t a, pix_t b);
		pix_t d;
		d = (a >= b) ? (a - b) : (b - a);
		return d >> 1;
	endfunction

endpackage

[rtl/core/gcdg_if.sv]
// Valid/ready channel interfaces for pixel input, result output and register writes.
// Depends on gcdg_pkg for field widths.

interface gcdg_pix_if import gcdg_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	pix_t red;
	pix_t green;
	pix_t blue;

	modport source(output valid, mode, red, green, blue, input ready);
	modport sink(input valid, mode, red, green, blue, output ready);
endinterface

interface gcdg_res_if import gcdg_pkg::*; ();
	logic valid;
	logic ready;
	pix_t magnitude;
	logic frame_last;

	modport source(output valid, magnitude, frame_last, input ready);
	modport sink(input valid, magnitude, frame_last, output ready);
endinterface

interface gcdg_cfg_if import gcdg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/gray_central_difference_gradient.sv]
// Streaming L1 gradient magnitude on the gray version of an RGB raster stream. Each
// accepted pixel becomes gray = (r*19661 + g*38666 + b*7209) >> 16 and is stored in a
// two-line buffer of 2*MAX_WIDTH bytes; the result for a pixel is |(E-W)/2| + |(S-N)/2|,
// or 0 on the first and last row and column, and it leaves width+1 pixel transfers
// after its own pixel. At the end of a frame, flush items (mode 1) drain the pending
// results one each; a flush in the middle of a frame is dropped. The block takes one
// item per clock while the result register does not stall it, since the line buffer
// serves the two neighbor-row reads of one pixel and the gray write of another in
// the same cycle; the result that an accepted item frees is loaded into the result
// register when that item leaves stage 1. The buffer is not cleared after reset.
// Write image_width and image_height only between frames, with all results taken.
// Depends on gcdg_pkg, gcdg_if and gcdg_line_buf.

module gray_central_difference_gradient import gcdg_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	gcdg_pix_if.sink    pix,
	gcdg_res_if.source  res,
	gcdg_cfg_if.sink    cfg
);

	// Frame geometry
	wid_t width_q;
	wid_t width_p1_q;
	col_t width_m1_q;
	row_t height_m1_q;

	// Input and output positions, pending result count
	row_t in_row_q;
	col_t in_col_q;
	row_t out_row_q;
	col_t out_col_q;
	wid_t owed_q;

	// Neighbor samples carried between pixels
	pix_t north_q;
	pix_t south_q;
	pix_t east1_q;
	pix_t east2_q;

	// Stage 1
	logic  valid_s1;
	logic  pix_s1;
	logic  res_s1;
	logic  mag_ok_s1;
	logic  last_s1;
	addr_t slot_s1;
	prod_t prod_r_s1;
	prod_t prod_g_s1;
	prod_t prod_b_s1;

	// Result register
	logic res_valid_q;
	pix_t res_mag_q;
	logic res_last_q;

	// Combinational
	logic    accept;
	logic    cfg_xfer;
	logic    is_flush;
	logic    q_bad;
	row_t    q_row;
	col_t    q_col;
	logic    q_past_row;
	logic    p_inner;
	logic    gives;
	logic    mag_ok;
	logic    out_free;
	logic    s1_go;
	addr_t   slot_q;
	addr_t   slot_e;
	prod_t   gray_sum;
	pix_t    gray_s1;
	pix_t    mag_s1;
	pix_t    evict_data;
	pix_t    east_data;
	int      dim_w;
	int      dim_h;
	lb_req_t lb_req;

	assign cfg.ready = 1'b1;
	assign cfg_xfer  = cfg.valid && cfg.ready;
	assign dim_w     = clamp_dim(cfg.data, MAX_WIDTH);
	assign dim_h     = clamp_dim(cfg.data, MAX_HEIGHT);

	// Handshake: stage 1 moves unless its result finds the output register full
	assign out_free  = !res_valid_q || res.ready;
	assign s1_go     = valid_s1 && (!res_s1 || out_free);
	assign pix.ready = !valid_s1 || s1_go;
	assign accept    = pix.valid && pix.ready;
	assign is_flush  = (pix.mode == MODE_FLUSH);

	// Clamp a stale input position to the frame start
	always_comb begin
		q_bad = (in_row_q > height_m1_q) || (in_col_q > width_m1_q);
		q_row = q_bad ? '0 : in_row_q;
		q_col = q_bad ? '0 : in_col_q;
	end

	// Decide whether this item frees a result and whether the result is interior
	always_comb begin
		q_past_row = (q_row >= ROW_W'(2)) || ((q_row == ROW_W'(1)) && (q_col != '0));
		p_inner    = (out_row_q != '0) && (out_row_q < height_m1_q) &&
			(out_col_q != '0) && (out_col_q < width_m1_q);
		if (is_flush) begin
			gives  = (q_row == '0) && (q_col == '0) && (owed_q != '0);
			mag_ok = 1'b0;
		end else begin
			gives  = owed_q > width_q;
			mag_ok = (owed_q == width_p1_q) && q_past_row && p_inner;
		end
	end

	// Line slots of this pixel and of the pixel one row above
	always_comb begin
		slot_q = q_row[0] ? (ADDR_W'(width_q) + ADDR_W'(q_col)) : ADDR_W'(q_col);
		slot_e = q_row[0] ? ADDR_W'(q_col) : (ADDR_W'(width_q) + ADDR_W'(q_col));
	end

	// Gray value and gradient in stage 1
	always_comb begin
		gray_sum = prod_r_s1 + prod_g_s1 + prod_b_s1;
		gray_s1  = gray_sum[GRAY_SHIFT +: PIX_W];
		mag_s1   = half_abs(east_data, east2_q) + half_abs(south_q, north_q);
	end

	// Reads on accept, write-back when the pixel leaves stage 1; the slots of
	// neighboring pixels differ for any width that has interior pixels
	always_comb begin
		lb_req.rd_en     = accept;
		lb_req.rd_a_addr = slot_q;
		lb_req.rd_b_addr = slot_e;
		lb_req.wr_en     = s1_go && pix_s1;
		lb_req.wr_addr   = slot_s1;
		lb_req.wr_data   = gray_s1;
	end

	gcdg_line_buf u_line_buf (
		.clk       (clk),
		.req       (lb_req),
		.rd_a_data (evict_data),
		.rd_b_data (east_data)
	);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= EW'(RST_W);
			width_p1_q  <= EW'(RST_W + 1);
			width_m1_q  <= COL_W'(RST_W - 1);
			height_m1_q <= ROW_W'(RST_H - 1);
		end else if (cfg_xfer) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_IMAGE_WIDTH: begin
					width_q    <= EW'(dim_w);
					width_p1_q <= EW'(dim_w + 1);
					width_m1_q <= COL_W'(dim_w - 1);
				end
				REG_IMAGE_HEIGHT: begin
					height_m1_q <= ROW_W'(dim_h - 1);
				end
			endcase
		end
	end

	// Advance positions and the pending count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			owed_q    <= '0;
		end else if (accept) begin
			if (is_flush) begin
				in_row_q <= q_row;
				in_col_q <= q_col;
				if (gives)
					owed_q <= owed_q - EW'(1);
			end else begin
				if (q_col == width_m1_q) begin
					in_col_q <= '0;
					in_row_q <= (q_row == height_m1_q) ? '0 : q_row + ROW_W'(1);
				end else begin
					in_row_q <= q_row;
					in_col_q <= q_col + COL_W'(1);
				end
				if (!gives)
					owed_q <= owed_q + EW'(1);
			end
			if (gives) begin
				if (out_col_q == width_m1_q) begin
					out_col_q <= '0;
					out_row_q <= (out_row_q == height_m1_q) ? '0 : out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload: weighted products and result attributes
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= !is_flush;
			res_s1    <= gives;
			mag_ok_s1 <= mag_ok;
			last_s1   <= (out_row_q == height_m1_q) && (out_col_q == width_m1_q);
			slot_s1   <= slot_q;
			prod_r_s1 <= PROD_W'(pix.red) * PROD_W'(WT_RED);
			prod_g_s1 <= PROD_W'(pix.green) * PROD_W'(WT_GREEN);
			prod_b_s1 <= PROD_W'(pix.blue) * PROD_W'(WT_BLUE);
		end
	end

	// Shift neighbor samples as each pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			north_q <= '0;
			south_q <= '0;
			east1_q <= '0;
			east2_q <= '0;
		end else if (s1_go && pix_s1) begin
			north_q <= evict_data;
			south_q <= gray_s1;
			east1_q <= east_data;
			east2_q <= east1_q;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && res_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload; border pixels give zero
	always_ff @(posedge clk) begin
		if (s1_go && res_s1) begin
			res_mag_q  <= mag_ok_s1 ? mag_s1 : '0;
			res_last_q <= last_s1;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.magnitude  = res_mag_q;
	assign res.frame_last = res_last_q;

	// The last pixel of a frame lies on the right border
	a_last_is_border: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_last |-> res.magnitude == '0)
		else $error("frame_last result with nonzero magnitude");

	// Two halved differences never reach the all-ones code
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.magnitude != '1)
		else $error("magnitude above 254");

	// A blocked result in stage 1 must stall the input
	a_input_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_s1 && res_valid_q && !res.ready |-> !pix.ready)
		else $error("input ready while stage 1 result is blocked");

	// A new result comes only from a stage 1 item that owes one
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && res_s1))
		else $error("result register loaded without a pending result");

endmodule

[rtl/core/gcdg_line_buf.sv]
// Two-line gray buffer: one synchronous write port and two registered read ports.
// Depends on gcdg_pkg for depth, address and request types.

module gcdg_line_buf import gcdg_pkg::*; (
	input  logic    clk,
	input  lb_req_t req,
	output pix_t    rd_a_data,
	output pix_t    rd_b_data
);

	pix_t mem [LB_DEPTH];

	// Write the new gray sample
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
	end

	// Read both ports; data holds until the next read
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_a_data <= mem[req.rd_a_addr];
			rd_b_data <= mem[req.rd_b_addr];
		end
	end

endmodule
